### hdl/rgbe_pkg.sv
// ----------------------------------------------------------------------------
// rgbe_pkg
// Shared types and constants for the RGBE scanline run-length decoder.
// ----------------------------------------------------------------------------
package rgbe_pkg;

  // field widths fixed by the stream format
  localparam int LW_BITS  = 15;   // line_width / line_count registers
  localparam int OUT_DIM  = 15;   // column / row result fields
  localparam int DIM_MAX  = 16;   // widest supported column counter

  localparam logic [7:0] RUN_BASE  = 8'h80;
  localparam logic [2:0] HDR_BYTES = 3'd4;

  // decode phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_COUNT  = 2'd1;
  localparam logic [1:0] PH_RUN    = 2'd2;
  localparam logic [1:0] PH_LIT    = 2'd3;

  localparam logic [1:0] PLANE_EXP = 2'd3;

  // configuration register indexes
  localparam logic CFG_LINE_WIDTH = 1'b0;
  localparam logic CFG_LINE_COUNT = 1'b1;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // one decoded value on its way to the back end
  typedef struct packed {
    logic [7:0]         value;
    logic [1:0]         channel;
    logic [DIM_MAX-1:0] column;
    logic [7:0]         rep;       // columns filled
    logic [7:0]         span;      // packet length left, for the overrun check
    logic               end_line;  // packet closed the exponent plane
    logic               restart;   // frame restarted since the last value
  } token_t;

endpackage

### hdl/rgbe_front.sv
// ----------------------------------------------------------------------------
// rgbe_front
// Byte classifier: header skip, packet counts, column and plane tracking.
// Emits one token per decoded value.
// ----------------------------------------------------------------------------
module rgbe_front import rgbe_pkg::*; #(
  parameter int DIM_BITS = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [LW_BITS-1:0] line_width,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               frame_start,
  output logic               push,
  output token_t             tok
);

  localparam int CW   = ((DIM_BITS > LW_BITS) ? DIM_BITS : LW_BITS) + 2;
  localparam int SUMW = DIM_BITS + 1;

  logic [1:0]          phase, phase_next;
  logic [2:0]          header_left, header_left_next;
  logic [1:0]          plane, plane_next;
  logic [DIM_BITS-1:0] col_count, col_count_next;
  logic [7:0]          literal_left, literal_left_next;
  logic [6:0]          run_length, run_length_next;
  logic                restart_pend, restart_pend_next;

  logic [7:0]          step;
  logic [SUMW-1:0]     col_sum;
  logic [DIM_BITS-1:0] col_sat;
  logic                at_end;
  logic                end_pkt;

  // saturating column advance and end-of-plane test
  always_comb begin
    step    = (phase == PH_RUN) ? {1'b0, run_length} : 8'd1;
    col_sum = {1'b0, col_count} + SUMW'(step);
    col_sat = col_sum[DIM_BITS] ? '1 : col_sum[DIM_BITS-1:0];
    at_end  = CW'(col_sat) >= CW'(line_width);
  end

  always_comb begin
    phase_next        = phase;
    header_left_next  = header_left;
    plane_next        = plane;
    col_count_next    = col_count;
    literal_left_next = literal_left;
    run_length_next   = run_length;
    restart_pend_next = restart_pend;
    push              = 1'b0;
    end_pkt           = 1'b0;
    tok               = '0;
    tok.value         = data_byte;
    tok.channel       = plane;
    tok.column        = DIM_MAX'(col_count);
    tok.restart       = restart_pend;

    if (accept) begin
      if (frame_start) begin
        // restart; this byte is the first header byte
        phase_next        = PH_HEADER;
        header_left_next  = HDR_BYTES - 3'd1;
        plane_next        = '0;
        col_count_next    = '0;
        literal_left_next = '0;
        run_length_next   = '0;
        restart_pend_next = 1'b1;
      end else begin
        unique case (phase)
          PH_HEADER: begin
            if (header_left > 3'd1) begin
              header_left_next = header_left - 3'd1;
            end else begin
              header_left_next = HDR_BYTES;
              phase_next       = PH_COUNT;
            end
          end
          PH_COUNT: begin
            if (data_byte > RUN_BASE) begin
              run_length_next = 7'(data_byte - RUN_BASE);
              phase_next      = PH_RUN;
            end else if (data_byte != 8'd0) begin
              literal_left_next = data_byte;
              phase_next        = PH_LIT;
            end
          end
          PH_RUN: begin
            push           = 1'b1;
            tok.rep        = {1'b0, run_length};
            tok.span       = {1'b0, run_length};
            col_count_next = col_sat;
            end_pkt        = 1'b1;
          end
          PH_LIT: begin
            push              = 1'b1;
            tok.rep           = 8'd1;
            tok.span          = literal_left;
            col_count_next    = col_sat;
            literal_left_next = literal_left - 8'd1;
            end_pkt           = (literal_left == 8'd1);
          end
          default: ;
        endcase

        if (end_pkt) begin
          phase_next = PH_COUNT;
          if (at_end) begin
            col_count_next = '0;
            if (plane != PLANE_EXP) begin
              plane_next = plane + 2'd1;
            end else begin
              plane_next       = '0;
              phase_next       = PH_HEADER;
              header_left_next = HDR_BYTES;
              tok.end_line     = 1'b1;
            end
          end
        end

        if (push) restart_pend_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_left  <= HDR_BYTES;
      plane        <= '0;
      col_count    <= '0;
      literal_left <= '0;
      run_length   <= '0;
      restart_pend <= 1'b0;
    end else begin
      phase        <= phase_next;
      header_left  <= header_left_next;
      plane        <= plane_next;
      col_count    <= col_count_next;
      literal_left <= literal_left_next;
      run_length   <= run_length_next;
      restart_pend <= restart_pend_next;
    end
  end

endmodule

### hdl/rgbe_queue.sv
// ----------------------------------------------------------------------------
// rgbe_queue
// Two-entry token queue between the front and back ends.
// ----------------------------------------------------------------------------
module rgbe_queue import rgbe_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  token_t push_tok,
  input  logic   pop,
  output logic   full,
  output logic   valid,
  output token_t head
);

  token_t               entry [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   fill;

  assign full  = (fill == Q_CNT_W'(Q_DEPTH));
  assign valid = (fill != '0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + Q_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + Q_PTR_W'(1);
      unique case ({push, pop})
        2'b10:   fill <= fill + Q_CNT_W'(1);
        2'b01:   fill <= fill - Q_CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

### hdl/rgbe_back.sv
// ----------------------------------------------------------------------------
// rgbe_back
// Row tracking, overrun and end-of-frame flags, and the result register.
// ----------------------------------------------------------------------------
module rgbe_back import rgbe_pkg::*; #(
  parameter int DIM_BITS = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [LW_BITS-1:0] line_width,
  input  logic [LW_BITS-1:0] line_count,
  input  logic               q_valid,
  input  token_t             q_head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         value,
  output logic [1:0]         channel,
  output logic [OUT_DIM-1:0] column,
  output logic [OUT_DIM-1:0] row,
  output logic [7:0]         repeat_res,
  output logic               overrun,
  output logic               frame_done
);

  localparam int CW   = ((DIM_BITS > LW_BITS) ? DIM_BITS : LW_BITS) + 2;
  localparam int SUMW = DIM_BITS + 1;

  logic [DIM_BITS-1:0] row_count;
  logic [DIM_BITS-1:0] row_used;
  logic [SUMW-1:0]     row_inc;
  logic [DIM_BITS-1:0] col_dim;
  logic [CW-1:0]       col_ext;
  logic [CW-1:0]       row_ext;
  logic                done;
  logic                ovr;

  assign pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    row_used = q_head.restart ? '0 : row_count;
    row_inc  = {1'b0, row_used} + SUMW'(1);
    done     = q_head.end_line && (CW'(row_inc) == CW'(line_count));
    col_dim  = q_head.column[DIM_BITS-1:0];
    ovr      = (CW'(col_dim) + CW'(q_head.span)) > CW'(line_width);
    col_ext  = CW'(col_dim);
    row_ext  = CW'(row_used);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      row_count <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        if (q_head.end_line) begin
          row_count <= done ? '0 : row_inc[DIM_BITS-1:0];
        end else begin
          row_count <= row_used;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      value      <= q_head.value;
      channel    <= q_head.channel;
      column     <= col_ext[OUT_DIM-1:0];
      row        <= row_ext[OUT_DIM-1:0];
      repeat_res <= q_head.rep;
      overrun    <= ovr;
      frame_done <= done;
    end
  end

endmodule

### hdl/rgbe_scanline_rle_decoder.sv
// ----------------------------------------------------------------------------
// rgbe_scanline_rle_decoder
// Adaptive run-length scanline decoder for RGBE pixel bytes.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, sustained, while the result side keeps up.
// Each value is written into the token queue and then into the result register;
// it can wait in the queue while the result side stalls.
// A two-entry token queue sits between the classifier and the result register;
// input stall rises only when that queue is full.
// Reset (rst, synchronous): header skip at row 0, line_width = line_count = 256.
// ----------------------------------------------------------------------------
module rgbe_scanline_rle_decoder import rgbe_pkg::*; #(
  parameter int DIM_BITS = 15
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [LW_BITS-1:0] cfg_data,
  // byte stream
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               frame_start,
  // decoded values
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         value,
  output logic [1:0]         channel,
  output logic [OUT_DIM-1:0] column,
  output logic [OUT_DIM-1:0] row,
  output logic [7:0]         repeat_res,
  output logic               overrun,
  output logic               frame_done
);

  logic [LW_BITS-1:0] line_width;
  logic [LW_BITS-1:0] line_count;
  logic               accept;
  logic               push;
  token_t             push_tok;
  logic               q_full;
  logic               q_valid;
  token_t             q_head;
  logic               pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LW_BITS'(256);
      line_count <= LW_BITS'(256);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_LINE_WIDTH: line_width <= cfg_data;
        CFG_LINE_COUNT: line_count <= cfg_data;
      endcase
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  rgbe_front #(.DIM_BITS(DIM_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .line_width  (line_width),
    .accept      (accept),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .push        (push),
    .tok         (push_tok)
  );

  rgbe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head)
  );

  rgbe_back #(.DIM_BITS(DIM_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .line_width (line_width),
    .line_count (line_count),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value      (value),
    .channel    (channel),
    .column     (column),
    .row        (row),
    .repeat_res (repeat_res),
    .overrun    (overrun),
    .frame_done (frame_done)
  );

endmodule

### hdl/rgbe_checker.sv
// ----------------------------------------------------------------------------
// rgbe_checker
// Port-level checks for the RGBE scanline decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rgbe_checker import rgbe_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [7:0]         value,
  input logic [1:0]         channel,
  input logic [OUT_DIM-1:0] column,
  input logic [OUT_DIM-1:0] row,
  input logic [7:0]         repeat_res,
  input logic               overrun,
  input logic               frame_done
);

  // held result must not move while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(column)
      && $stable(row) && $stable(repeat_res) && $stable(channel))
    else $error("result changed while stalled");

  // repeat count stays within 1..128: a run never covers more than 127 columns, a literal exactly one
  a_rep_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> repeat_res != 8'd0 && repeat_res <= 8'd128)
    else $error("repeat count out of range");

  // a frame can only close on the exponent plane
  a_done_plane: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> channel == PLANE_EXP)
    else $error("frame done outside exponent plane");

  // reset leaves no result pending and the queue open
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("state not cleared by reset");

endmodule

bind rgbe_scanline_rle_decoder rgbe_checker u_checker (.*);
